### rtl/core/ifd_pkg.sv
// Shared types and constants of the IR file transfer deframer.
package ifd_pkg;

	localparam int unsigned NAME_LEN = 32;
	localparam int unsigned NIDX_W = $clog2(NAME_LEN);

	localparam logic [7:0] NAME_ADDR_RST = 8'hF0;
	localparam logic [7:0] SIZE_ADDR_RST = 8'h10;
	localparam logic [7:0] DATA_ADDR_RST = 8'h01;
	localparam logic [7:0] CHECK_ADDR_RST = 8'h30;

	typedef enum logic [1:0] {
		REG_NAME_ADDR  = 2'd0,
		REG_SIZE_ADDR  = 2'd1,
		REG_DATA_ADDR  = 2'd2,
		REG_CHECK_ADDR = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		EV_IGNORED    = 4'd0,
		EV_NAME_CHAR  = 4'd1,
		EV_NAME_END   = 4'd2,
		EV_NAME_LONG  = 4'd3,
		EV_SIZE_BYTE  = 4'd4,
		EV_SESS_START = 4'd5,
		EV_DATA       = 4'd6,
		EV_EXTRA_DATA = 4'd7,
		EV_CHECK_OK   = 4'd8,
		EV_CHECK_ERR  = 4'd9
	} event_t;

	typedef struct packed {
		logic [7:0] name_address;
		logic [7:0] size_address;
		logic [7:0] data_address;
		logic [7:0] check_address;
	} cfg_t;

	typedef struct packed {
		logic [7:0] frame_address;
		logic [7:0] frame_command;
	} frame_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  payload;
		logic        session_aborted;
		logic [31:0] total_size;
		logic [31:0] received_count;
		logic [4:0]  name_position;
	} result_t;

endpackage

### rtl/core/ifd_cfg_regs.sv
// Address configuration registers of the deframer.
module ifd_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output ifd_pkg::cfg_t     cfg
);
	import ifd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_address  <= NAME_ADDR_RST;
			cfg_q.size_address  <= SIZE_ADDR_RST;
			cfg_q.data_address  <= DATA_ADDR_RST;
			cfg_q.check_address <= CHECK_ADDR_RST;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_NAME_ADDR:  cfg_q.name_address  <= cfg_data;
				REG_SIZE_ADDR:  cfg_q.size_address  <= cfg_data;
				REG_DATA_ADDR:  cfg_q.data_address  <= cfg_data;
				REG_CHECK_ADDR: cfg_q.check_address <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/ifd_core.sv
// Frame classification and session state of the deframer.
module ifd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ifd_pkg::frame_t    frame,
	input  ifd_pkg::cfg_t      cfg,
	output ifd_pkg::result_t   result
);
	import ifd_pkg::*;

	logic              receiving_q;
	logic              name_finished_q;
	logic [NIDX_W-1:0] name_index_q;
	logic [1:0]        size_cnt_q;
	logic [31:0]       size_shift_q;
	logic [31:0]       expected_q;
	logic [31:0]       byte_count_q;
	logic [7:0]        xor_q;

	logic              receiving_d;
	logic              name_finished_d;
	logic [NIDX_W-1:0] name_index_d;
	logic [1:0]        size_cnt_d;
	logic [31:0]       size_shift_d;
	logic [31:0]       expected_d;
	logic [31:0]       byte_count_d;
	logic [7:0]        xor_d;

	event_t            ev;
	logic [7:0]        pay;
	logic              aborted;
	logic [31:0]       shift_next;

	assign shift_next = {size_shift_q[23:0], frame.frame_command};

	always_comb begin
		receiving_d     = receiving_q;
		name_finished_d = name_finished_q;
		name_index_d    = name_index_q;
		size_cnt_d      = size_cnt_q;
		size_shift_d    = size_shift_q;
		expected_d      = expected_q;
		byte_count_d    = byte_count_q;
		xor_d           = xor_q;
		ev              = EV_IGNORED;
		pay             = 8'd0;
		aborted         = 1'b0;

		if (frame.frame_address == cfg.name_address) begin
			// A name frame in the middle of a session or size throws the session away.
			if (receiving_q || (byte_count_q != 32'd0) || (size_cnt_q != 2'd0)) begin
				receiving_d     = 1'b0;
				size_cnt_d      = 2'd0;
				size_shift_d    = 32'd0;
				byte_count_d    = 32'd0;
				xor_d           = 8'd0;
				expected_d      = 32'd0;
				name_index_d    = '0;
				name_finished_d = 1'b0;
				aborted         = 1'b1;
			end
			if (!name_finished_d) begin
				if (name_index_d < NIDX_W'(NAME_LEN - 1)) begin
					if (frame.frame_command == 8'd0) begin
						name_index_d    = '0;
						name_finished_d = 1'b1;
						ev              = EV_NAME_END;
					end else begin
						name_index_d = name_index_d + 1'b1;
						ev           = EV_NAME_CHAR;
						pay          = frame.frame_command;
					end
				end else begin
					name_index_d = '0;
					ev           = EV_NAME_LONG;
				end
			end
		end else if (frame.frame_address == cfg.size_address) begin
			if (!receiving_q) begin
				size_shift_d = shift_next;
				if (size_cnt_q == 2'd3) begin
					expected_d   = shift_next;
					receiving_d  = 1'b1;
					byte_count_d = 32'd0;
					xor_d        = 8'd0;
					size_cnt_d   = 2'd0;
					ev           = EV_SESS_START;
				end else begin
					size_cnt_d = size_cnt_q + 2'd1;
					ev         = EV_SIZE_BYTE;
				end
			end
		end else if (frame.frame_address == cfg.data_address) begin
			if (receiving_q) begin
				if (byte_count_q >= expected_q) begin
					ev = EV_EXTRA_DATA;
				end else begin
					byte_count_d = byte_count_q + 32'd1;
					xor_d        = xor_q ^ frame.frame_command;
					ev           = EV_DATA;
					pay          = frame.frame_command;
				end
			end
		end else if (frame.frame_address == cfg.check_address) begin
			ev              = (xor_q == frame.frame_command) ? EV_CHECK_OK : EV_CHECK_ERR;
			receiving_d     = 1'b0;
			size_cnt_d      = 2'd0;
			size_shift_d    = 32'd0;
			byte_count_d    = 32'd0;
			xor_d           = 8'd0;
			name_finished_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q     <= 1'b0;
			name_finished_q <= 1'b0;
			name_index_q    <= '0;
			size_cnt_q      <= 2'd0;
			size_shift_q    <= 32'd0;
			expected_q      <= 32'd0;
			byte_count_q    <= 32'd0;
			xor_q           <= 8'd0;
		end else if (fire) begin
			receiving_q     <= receiving_d;
			name_finished_q <= name_finished_d;
			name_index_q    <= name_index_d;
			size_cnt_q      <= size_cnt_d;
			size_shift_q    <= size_shift_d;
			expected_q      <= expected_d;
			byte_count_q    <= byte_count_d;
			xor_q           <= xor_d;
		end
	end

	always_comb begin
		result.event_res       = ev;
		result.payload         = pay;
		result.session_aborted = aborted;
		result.total_size      = expected_d;
		result.received_count  = byte_count_d;
		result.name_position   = 5'(name_index_d);
	end

endmodule

### rtl/core/ir_file_transfer_deframer.sv
// Top level of the IR file transfer deframer.
// Pipeline: a frame accepted into the input register moves into the result register and onto
// out_data once that register is empty or drained. Throughput: one frame per cycle unless
// out_stall holds it; the session state is updated as the frame enters the result register.
// Reset clears all session state and the pipeline valids, and loads the default
// addresses (name 0xF0, size 0x10, data 0x01, check 0x30).
module ir_file_transfer_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ifd_pkg::frame_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ifd_pkg::result_t  out_data,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);
	import ifd_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	frame_t  frame_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    advance;
	logic    fire;

	// The result register takes a new transaction when it is empty or being drained.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	ifd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ifd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.frame  (frame_s1),
		.cfg    (cfg),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			frame_s1 <= in_data;
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

### tb/tb_ir_file_transfer_deframer.sv
// Self-checking testbench of the IR file transfer deframer, with its own frame predictor.
`timescale 1ns / 1ps

module tb_ir_file_transfer_deframer;
	import ifd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 300;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	frame_t  in_data = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	result_t out_data;
	logic    cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	ir_file_transfer_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted deframer state.
	cfg_t              addr_map;
	bit                rx_active;
	bit                name_closed;
	logic [NIDX_W-1:0] name_idx;
	int unsigned       size_count;
	logic [31:0]       size_accum;
	logic [31:0]       sess_len;
	logic [31:0]       data_count;
	logic [7:0]        data_xor;

	result_t     expected_results[$];
	int unsigned error_count = 0;
	int unsigned useful_frames = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on = 1'b1;
	int unsigned hold_token = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	function automatic void clear_session_state();
		rx_active = 1'b0;
		size_count = 0;
		size_accum = '0;
		data_count = '0;
		data_xor = '0;
	endfunction

	function automatic void reset_predictor();
		addr_map.name_address = NAME_ADDR_RST;
		addr_map.size_address = SIZE_ADDR_RST;
		addr_map.data_address = DATA_ADDR_RST;
		addr_map.check_address = CHECK_ADDR_RST;
		clear_session_state();
		name_closed = 1'b0;
		name_idx = '0;
		sess_len = '0;
	endfunction

	function automatic result_t deframe_frame(frame_t f);
		result_t r;
		r = '0;
		r.event_res = EV_IGNORED;
		// Address classes are tested in a fixed order, so overlapping addresses
		// resolve to the first match.
		if (f.frame_address == addr_map.name_address) begin
			if (rx_active || data_count != 0 || size_count != 0) begin
				clear_session_state();
				sess_len = '0;
				name_idx = '0;
				name_closed = 1'b0;
				r.session_aborted = 1'b1;
			end
			if (!name_closed) begin
				if (name_idx < NAME_LEN - 1) begin
					if (f.frame_command == 8'h00) begin
						name_idx = '0;
						name_closed = 1'b1;
						r.event_res = EV_NAME_END;
					end else begin
						name_idx = name_idx + 1'b1;
						r.event_res = EV_NAME_CHAR;
						r.payload = f.frame_command;
					end
				end else begin
					name_idx = '0;
					r.event_res = EV_NAME_LONG;
				end
			end
		end else if (f.frame_address == addr_map.size_address) begin
			if (!rx_active) begin
				size_accum = {size_accum[23:0], f.frame_command};
				size_count++;
				if (size_count == 4) begin
					sess_len = size_accum;
					rx_active = 1'b1;
					data_count = '0;
					data_xor = '0;
					size_count = 0;
					r.event_res = EV_SESS_START;
				end else begin
					r.event_res = EV_SIZE_BYTE;
				end
			end
		end else if (f.frame_address == addr_map.data_address) begin
			if (rx_active) begin
				if (data_count >= sess_len) begin
					r.event_res = EV_EXTRA_DATA;
				end else begin
					data_count = data_count + 1;
					data_xor = data_xor ^ f.frame_command;
					r.event_res = EV_DATA;
					r.payload = f.frame_command;
				end
			end
		end else if (f.frame_address == addr_map.check_address) begin
			r.event_res = (data_xor == f.frame_command) ? EV_CHECK_OK : EV_CHECK_ERR;
			clear_session_state();
			name_closed = 1'b0;
		end
		r.total_size = sess_len;
		r.received_count = data_count;
		r.name_position = name_idx;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!gaps_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	// Offers one frame and records its predicted event once the transaction completes.
	task automatic send_frame(logic [7:0] addr, logic [7:0] cmd);
		frame_t      f;
		result_t     r;
		int unsigned gap;
		f.frame_address = addr;
		f.frame_command = cmd;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		r = deframe_frame(f);
		if (r.event_res != EV_IGNORED)
			useful_frames++;
		expected_results.push_back(r);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(reg_index_t idx, logic [7:0] value);
		wait_for_results();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_NAME_ADDR:  addr_map.name_address = value;
			REG_SIZE_ADDR:  addr_map.size_address = value;
			REG_DATA_ADDR:  addr_map.data_address = value;
			REG_CHECK_ADDR: addr_map.check_address = value;
			default: ;
		endcase
	endtask

	// An optional name, four size bytes, data frames and a checksum; a broken session gets a
	// name frame in the middle of its data.
	task automatic send_session(int unsigned name_len, logic [31:0] size,
			int unsigned data_frames, bit good_check, bit broken);
		for (int unsigned i = 0; i < name_len; i++)
			send_frame(addr_map.name_address, 8'($urandom_range(1, 255)));
		if (name_len != 0)
			send_frame(addr_map.name_address, 8'h00);
		for (int b = 0; b < 4; b++)
			send_frame(addr_map.size_address, 8'(size >> (24 - 8 * b)));
		for (int unsigned i = 0; i < data_frames; i++) begin
			if (broken && i == data_frames / 2)
				send_frame(addr_map.name_address, 8'($urandom_range(0, 255)));
			send_frame(addr_map.data_address, 8'($urandom_range(0, 255)));
		end
		send_frame(addr_map.check_address, good_check ? data_xor : 8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed_frames();
		send_frame(8'hF0, 8'h61);
		send_frame(8'hF0, 8'hFF);
		send_frame(8'hF0, 8'h00);
		send_frame(8'hF0, 8'h62);
		send_frame(8'h30, 8'h00);
		send_frame(8'h30, 8'h55);
		send_frame(8'h10, 8'h00);
		send_frame(8'h10, 8'h00);
		send_frame(8'h10, 8'h00);
		send_frame(8'h10, 8'h03);
		send_frame(8'h10, 8'h7F);
		send_frame(8'h01, 8'h00);
		send_frame(8'h01, 8'hFF);
		send_frame(8'h01, 8'hA5);
		send_frame(8'h01, 8'h3C);
		send_frame(8'h30, 8'h5A);
		send_frame(8'h01, 8'h11);
		send_frame(8'h77, 8'hFF);
		// A partly assembled size is dropped by a name frame.
		send_frame(8'h10, 8'h12);
		send_frame(8'hF0, 8'h7A);
		// A zero size makes every data frame extra.
		for (int i = 0; i < 4; i++)
			send_frame(8'h10, 8'h00);
		send_frame(8'h01, 8'h42);
		send_frame(8'h30, 8'h00);
	endtask

	task automatic test_name_overflow();
		for (int i = 0; i < NAME_LEN; i++)
			send_frame(addr_map.name_address, 8'($urandom_range(1, 255)));
		send_frame(addr_map.name_address, 8'h00);
		send_frame(addr_map.check_address, 8'h00);
	endtask

	task automatic test_register_settings();
		write_register(REG_NAME_ADDR, 8'h00);
		write_register(REG_SIZE_ADDR, 8'h00);
		write_register(REG_DATA_ADDR, 8'h00);
		write_register(REG_CHECK_ADDR, 8'h00);
		send_frame(8'h00, 8'h78);
		send_frame(8'h00, 8'h00);
		send_frame(8'h00, 8'h12);
		send_frame(8'h01, 8'h33);

		// Size shares its address with data and check, so size wins.
		write_register(REG_NAME_ADDR, 8'h11);
		write_register(REG_SIZE_ADDR, 8'h22);
		write_register(REG_DATA_ADDR, 8'h22);
		write_register(REG_CHECK_ADDR, 8'h22);
		for (int i = 0; i < 5; i++)
			send_frame(8'h22, 8'($urandom_range(0, 255)));
		send_frame(8'h11, 8'h00);
		write_register(REG_CHECK_ADDR, 8'h33);
		send_frame(8'h33, 8'h00);

		write_register(REG_NAME_ADDR, 8'hFF);
		write_register(REG_SIZE_ADDR, 8'h00);
		write_register(REG_DATA_ADDR, 8'h80);
		write_register(REG_CHECK_ADDR, 8'h7F);
		send_session(3, 32'd4, 5, 1'b1, 1'b0);
		send_session(0, 32'd2, 2, 1'b0, 1'b0);

		write_register(REG_NAME_ADDR, 8'h80);
		write_register(REG_SIZE_ADDR, 8'h7F);
		write_register(REG_DATA_ADDR, 8'hFE);
		write_register(REG_CHECK_ADDR, 8'hFF);
		send_session(2, 32'd3, 3, 1'b1, 1'b1);

		write_register(REG_NAME_ADDR, NAME_ADDR_RST);
		write_register(REG_SIZE_ADDR, SIZE_ADDR_RST);
		write_register(REG_DATA_ADDR, DATA_ADDR_RST);
		write_register(REG_CHECK_ADDR, CHECK_ADDR_RST);
	endtask

	// The receiver holds off for a long stretch while frames keep coming back to back.
	task automatic test_output_hold();
		gaps_on = 1'b0;
		hold_token++;
		send_session(2, 32'd24, 24, 1'b1, 1'b0);
		send_session(0, 32'd6, 6, 1'b1, 1'b0);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic(int unsigned target);
		int unsigned goal;
		int unsigned nlen;
		int unsigned ndata;
		logic [31:0] sz;
		logic [7:0]  addr;
		goal = useful_frames + target;
		while (useful_frames < goal) begin
			if ($urandom_range(0, 99) < 70) begin
				if ($urandom_range(0, 3) == 0)
					nlen = 0;
				else if ($urandom_range(0, 7) == 0)
					nlen = $urandom_range(28, 36);
				else
					nlen = $urandom_range(1, 6);
				sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 10);
				ndata = (sz > 10) ? $urandom_range(0, 10) : sz + $urandom_range(0, 2);
				send_session(nlen, sz, ndata, $urandom_range(0, 4) != 0,
					$urandom_range(0, 7) == 0);
			end else begin
				case ($urandom_range(0, 4))
					0: addr = addr_map.name_address;
					1: addr = addr_map.size_address;
					2: addr = addr_map.data_address;
					3: addr = addr_map.check_address;
					default: addr = 8'($urandom_range(0, 255));
				endcase
				send_frame(addr, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Receiver stall: random short and long stalls, plus the long hold on request.
	always @(posedge clk) begin
		if (hold_token != hold_served) begin
			hold_served = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 99) < 20) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected, event", 32'(out_data.event_res), '0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.event_res !== want.event_res)
					report_mismatch("event_res", 32'(out_data.event_res), 32'(want.event_res));
				if (out_data.payload !== want.payload)
					report_mismatch("payload", 32'(out_data.payload), 32'(want.payload));
				if (out_data.session_aborted !== want.session_aborted)
					report_mismatch("session_aborted", 32'(out_data.session_aborted),
						32'(want.session_aborted));
				if (out_data.total_size !== want.total_size)
					report_mismatch("total_size", out_data.total_size, want.total_size);
				if (out_data.received_count !== want.received_count)
					report_mismatch("received_count", out_data.received_count,
						want.received_count);
				if (out_data.name_position !== want.name_position)
					report_mismatch("name_position", 32'(out_data.name_position),
						32'(want.name_position));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		reset_predictor();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_name_overflow();
		test_register_settings();
		test_output_hold();
		test_random_traffic(130);
		gaps_on = 1'b0;
		test_random_traffic(40);
		gaps_on = 1'b1;
		test_random_traffic(130);
		wait_for_results();
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never delivered", expected_results.size(), '0);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
